### rtl/core/bmc_pkg.sv
// Shared types and constants of the blocking message channel.
package bmc_pkg;

    localparam int TID_W = 8;
    localparam int CAP_W = 6;

    typedef enum logic {
        K_READ  = 1'b0,
        K_WRITE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_BLOCK = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // classified operation header passed from the front to the back
    typedef struct packed {
        t_kind             kind;
        logic [TID_W-1:0]  thread_id;
    } t_tag;

    // control part of one result item
    typedef struct packed {
        t_status           status;
        logic              read_valid;
        logic              wake_valid;
        logic [TID_W-1:0]  wake_thread;
        logic              handoff_valid;
    } t_res_flags;

endpackage

### rtl/core/bmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bmc_front.sv
// Front stage: takes input items, classifies the operation and registers them.
module bmc_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [bmc_pkg::TID_W-1:0]     i_tid,
    input  logic [DATA_WIDTH-1:0]         i_val,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bmc_pkg::t_tag                 o_tag,
    output logic [DATA_WIDTH-1:0]         o_val
);
    import bmc_pkg::*;

    logic                  r_valid;
    t_tag                  r_tag;
    logic [DATA_WIDTH-1:0] r_val;
    t_tag                  n_tag;
    logic                  take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_tag.kind      = i_kind ? K_WRITE : K_READ;
        n_tag.thread_id = i_tid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_tag <= n_tag;
            r_val <= i_val;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_val   = r_val;

endmodule

### rtl/core/bmc_queue.sv
// Two-entry queue decoupling the front stage from the execution back end.
module bmc_queue #(
    parameter int WIDTH = 41
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WIDTH-1:0]  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WIDTH-1:0]  o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/core/bmc_back.sv
// Back end: occupancy bookkeeping, message and waiter FIFOs, result register.
module bmc_back #(
    parameter int MSG_DEPTH  = 64,
    parameter int WAIT_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bmc_pkg::CAP_W-1:0]     i_cfg_data,
    input  logic                          i_op_valid,
    output logic                          o_op_ready,
    input  bmc_pkg::t_tag                 i_op_tag,
    input  logic [DATA_WIDTH-1:0]         i_op_val,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output bmc_pkg::t_res_flags           o_res_flags,
    output logic [DATA_WIDTH-1:0]         o_res_read_data,
    output logic [DATA_WIDTH-1:0]         o_res_handoff_data
);
    import bmc_pkg::*;

    localparam int MAW  = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int WAW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int MCW  = $clog2(MSG_DEPTH + 1);
    localparam int WCW  = $clog2(WAIT_DEPTH + 1);
    localparam int MAXO = (MSG_DEPTH > WAIT_DEPTH) ? MSG_DEPTH : WAIT_DEPTH;
    localparam int OW   = $clog2(MAXO + 1) + 1;
    localparam int CW   = OW + 7;

    typedef enum logic {
        S_EXEC,
        S_RESP
    } t_state;

    t_state                  r_state, n_state;
    logic signed [OW-1:0]    r_occ, n_occ;
    logic [MAW-1:0]          r_mhead, n_mhead;
    logic [MCW-1:0]          r_mcnt, n_mcnt;
    logic [WAW-1:0]          r_whead, n_whead;
    logic [WCW-1:0]          r_wcnt, n_wcnt;
    logic [CAP_W-1:0]        r_cap, n_cap;
    logic                    r_res_valid, n_res_valid;
    t_res_flags              r_pend, n_pend;
    logic [DATA_WIDTH-1:0]   r_pend_hd, n_pend_hd;
    t_res_flags              r_res, n_res;
    logic [DATA_WIDTH-1:0]   r_res_rd, n_res_rd;
    logic [DATA_WIDTH-1:0]   r_res_hd, n_res_hd;

    logic                    m_we, m_re;
    logic [MAW-1:0]          m_tail;
    logic [DATA_WIDTH-1:0]   m_rdata;
    logic                    w_we, w_re;
    logic [WAW-1:0]          w_tail;
    logic [TID_W-1:0]        w_rdata;

    logic [MAW:0]            m_sum;
    logic [WAW:0]            w_sum;
    logic signed [CW-1:0]    occ_x, cap_x;
    logic                    occ_le0, occ_lt0, gt_cap, ge_cap;
    logic                    msg_full, wait_full, wait_any;
    logic                    op_go, out_free;

    // ring tails: head + count, wrapped once
    always_comb begin
        m_sum  = {1'b0, r_mhead} + (MAW+1)'(r_mcnt);
        w_sum  = {1'b0, r_whead} + (WAW+1)'(r_wcnt);
        m_tail = (m_sum >= (MAW+1)'(MSG_DEPTH)) ? MAW'(m_sum - (MAW+1)'(MSG_DEPTH))
                                                 : MAW'(m_sum);
        w_tail = (w_sum >= (WAW+1)'(WAIT_DEPTH)) ? WAW'(w_sum - (WAW+1)'(WAIT_DEPTH))
                                                  : WAW'(w_sum);
    end

    always_comb begin
        occ_x     = $signed({{7{r_occ[OW-1]}}, r_occ});
        cap_x     = $signed({{(OW+1){1'b0}}, r_cap});
        occ_lt0   = r_occ[OW-1];
        occ_le0   = occ_lt0 || (r_occ == '0);
        gt_cap    = occ_x > cap_x;
        ge_cap    = occ_x >= cap_x;
        msg_full  = (r_mcnt == MCW'(MSG_DEPTH));
        wait_full = (r_wcnt == WCW'(WAIT_DEPTH));
        wait_any  = (r_wcnt != '0);
        op_go     = (r_state == S_EXEC) && i_op_valid;
        out_free  = !r_res_valid || i_res_ready;
    end

    assign o_op_ready = (r_state == S_EXEC);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_mhead     = r_mhead;
        n_mcnt      = r_mcnt;
        n_whead     = r_whead;
        n_wcnt      = r_wcnt;
        n_cap       = r_cap;
        n_res_valid = r_res_valid;
        n_pend      = r_pend;
        n_pend_hd   = r_pend_hd;
        n_res       = r_res;
        n_res_rd    = r_res_rd;
        n_res_hd    = r_res_hd;
        m_we        = 1'b0;
        m_re        = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end
        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            S_EXEC: begin
                if (op_go) begin
                    n_pend.status        = ST_DONE;
                    n_pend.read_valid    = 1'b0;
                    n_pend.wake_valid    = 1'b0;
                    n_pend.wake_thread   = '0;
                    n_pend.handoff_valid = 1'b0;
                    n_pend_hd            = '0;
                    n_state              = S_RESP;
                    if (i_op_tag.kind == K_READ) begin
                        if (occ_le0) begin
                            if (wait_full) begin
                                n_pend.status = ST_FULL;
                            end else begin
                                w_we          = 1'b1;
                                n_wcnt        = r_wcnt + WCW'(1);
                                n_occ         = r_occ - OW'(1);
                                n_pend.status = ST_BLOCK;
                            end
                        end else begin
                            m_re              = 1'b1;
                            n_mhead           = (r_mhead == MAW'(MSG_DEPTH - 1)) ? '0
                                                : r_mhead + MAW'(1);
                            n_mcnt            = r_mcnt - MCW'(1);
                            n_occ             = r_occ - OW'(1);
                            n_pend.read_valid = 1'b1;
                            // more than capacity buffered: a writer is parked
                            if (gt_cap && wait_any) begin
                                w_re              = 1'b1;
                                n_whead           = (r_whead == WAW'(WAIT_DEPTH - 1)) ? '0
                                                    : r_whead + WAW'(1);
                                n_wcnt            = r_wcnt - WCW'(1);
                                n_pend.wake_valid = 1'b1;
                            end
                        end
                    end else begin
                        if (occ_lt0) begin
                            if (wait_any) begin
                                w_re                 = 1'b1;
                                n_whead              = (r_whead == WAW'(WAIT_DEPTH - 1)) ? '0
                                                       : r_whead + WAW'(1);
                                n_wcnt               = r_wcnt - WCW'(1);
                                n_pend.wake_valid    = 1'b1;
                                n_pend.handoff_valid = 1'b1;
                                n_pend_hd            = i_op_val;
                            end
                            n_occ = r_occ + OW'(1);
                        end else if (msg_full || (ge_cap && wait_full)) begin
                            n_pend.status = ST_FULL;
                        end else begin
                            m_we   = 1'b1;
                            n_mcnt = r_mcnt + MCW'(1);
                            n_occ  = r_occ + OW'(1);
                            if (ge_cap) begin
                                w_we          = 1'b1;
                                n_wcnt        = r_wcnt + WCW'(1);
                                n_pend.status = ST_BLOCK;
                            end
                        end
                    end
                end
            end
            S_RESP: begin
                // RAM read data is held until the result register frees up
                if (out_free) begin
                    n_res_valid       = 1'b1;
                    n_res             = r_pend;
                    n_res.wake_thread = r_pend.wake_valid ? w_rdata : '0;
                    n_res_rd          = r_pend.read_valid ? m_rdata : '0;
                    n_res_hd          = r_pend_hd;
                    n_state           = S_EXEC;
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_occ       <= '0;
            r_mhead     <= '0;
            r_mcnt      <= '0;
            r_whead     <= '0;
            r_wcnt      <= '0;
            r_cap       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_mhead     <= n_mhead;
            r_mcnt      <= n_mcnt;
            r_whead     <= n_whead;
            r_wcnt      <= n_wcnt;
            r_cap       <= n_cap;
            r_res_valid <= n_res_valid;
        end
        r_pend    <= n_pend;
        r_pend_hd <= n_pend_hd;
        r_res     <= n_res;
        r_res_rd  <= n_res_rd;
        r_res_hd  <= n_res_hd;
    end

    bmc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_tail),
        .i_wdata (i_op_val),
        .i_re    (m_re),
        .i_raddr (r_mhead),
        .o_rdata (m_rdata)
    );

    bmc_ram #(
        .WIDTH (TID_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tail),
        .i_wdata (i_op_tag.thread_id),
        .i_re    (w_re),
        .i_raddr (r_whead),
        .o_rdata (w_rdata)
    );

    assign o_res_valid        = r_res_valid;
    assign o_res_flags        = r_res;
    assign o_res_read_data    = r_res_rd;
    assign o_res_handoff_data = r_res_hd;

endmodule

### rtl/core/blocking_message_channel_unit.sv
// Top level of the blocking message channel: front stage, queue and back end.
//
//  channel   direction  signals                        item contents (lowest bit first)
//  s_axis    in         tvalid tready tdata tuser      tuser: kind; tdata: thread_id, msg_value
//  m_axis    out        tvalid tready tdata            tdata: status, read_valid, read_data,
//                                                      wake_valid, wake_thread, handoff_valid,
//                                                      handoff_data
//  cfg       in         i_cfg_valid o_cfg_ready        i_cfg_data: capacity
//
//  Back end: S_EXEC decides and issues the FIFO RAM accesses, then S_RESP collects the
//  registered RAM read data into the result register; no new item is taken meanwhile.
//  An accepted item passes the front register, queue, S_EXEC and S_RESP to the result.
//  Reset (synchronous, active low) clears occupancy, FIFO pointers and capacity; no
//  clearing pass runs, the block takes items from the first cycle after reset.
//  A stalled output holds the back end; the two-entry queue and front register keep
//  taking items until they fill.
module blocking_message_channel_unit #(
    parameter int MSG_DEPTH  = 64,
    parameter int WAIT_DEPTH = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IN_BITS  = bmc_pkg::TID_W + DATA_WIDTH,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = $bits(bmc_pkg::t_status) + 3 + bmc_pkg::TID_W + 2 * DATA_WIDTH,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,   // thread_id, msg_value
    input  logic                          s_axis_tuser,   // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata,   // status, read_valid, read_data,
                                                          // wake_valid, wake_thread,
                                                          // handoff_valid, handoff_data
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bmc_pkg::CAP_W-1:0]     i_cfg_data
);
    import bmc_pkg::*;

    localparam int Q_W      = $bits(t_tag) + DATA_WIDTH;

    logic                   f_valid, f_ready;
    t_tag                   f_tag;
    logic [DATA_WIDTH-1:0]  f_val;
    logic                   q_valid, q_ready;
    logic [Q_W-1:0]         q_data;
    t_tag                   q_tag;
    logic [DATA_WIDTH-1:0]  q_val;
    t_res_flags             res_flags;
    logic [DATA_WIDTH-1:0]  res_rd, res_hd;

    bmc_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_tid   (s_axis_tdata[TID_W-1:0]),
        .i_val   (s_axis_tdata[TID_W +: DATA_WIDTH]),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_tag   (f_tag),
        .o_val   (f_val)
    );

    bmc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_val, f_tag}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign q_tag = t_tag'(q_data[$bits(t_tag)-1:0]);
    assign q_val = q_data[$bits(t_tag) +: DATA_WIDTH];

    bmc_back #(
        .MSG_DEPTH  (MSG_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_op_valid         (q_valid),
        .o_op_ready         (q_ready),
        .i_op_tag           (q_tag),
        .i_op_val           (q_val),
        .o_res_valid        (m_axis_tvalid),
        .i_res_ready        (m_axis_tready),
        .o_res_flags        (res_flags),
        .o_res_read_data    (res_rd),
        .o_res_handoff_data (res_hd)
    );

    assign m_axis_tdata = OUT_W'({res_hd, res_flags.handoff_valid, res_flags.wake_thread,
                                  res_flags.wake_valid, res_rd, res_flags.read_valid,
                                  res_flags.status});
    assign o_cfg_ready  = 1'b1;

endmodule

### rtl/core/bmc_checker.sv
// Port-level checks on the blocking message channel, bound to the top level.
module bmc_port_checks #(
    parameter int DATA_WIDTH = 32,
    localparam int OUT_BITS = $bits(bmc_pkg::t_status) + 3 + bmc_pkg::TID_W + 2 * DATA_WIDTH,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [OUT_W-1:0]              m_axis_tdata
);
    import bmc_pkg::*;

    localparam int RV_B     = 2;
    localparam int WV_B     = RV_B + 1 + DATA_WIDTH;
    localparam int HV_B     = WV_B + 1 + TID_W;

    logic [1:0] status;
    logic       rv, wv, hv;

    assign status = m_axis_tdata[1:0];
    assign rv     = m_axis_tdata[RV_B];
    assign wv     = m_axis_tdata[WV_B];
    assign hv     = m_axis_tdata[HV_B];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (status == ST_DONE || status == ST_BLOCK || status == ST_FULL))
        else $error("undefined status code");

    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && hv |-> wv && !rv && status == ST_DONE)
        else $error("handoff without a woken reader");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_FULL |-> !rv && !wv && !hv)
        else $error("rejected item with side effects");

endmodule

bind blocking_message_channel_unit bmc_port_checks #(
    .DATA_WIDTH (DATA_WIDTH)
) u_bmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
